[sv/fst_pkg.sv]
// shared types, codes and a lookup function for the format spec tokenizer
package fst_pkg;

  localparam int NUM_W = 16;
  localparam int ACC_W = NUM_W + 4;
  localparam logic [ACC_W-1:0] NUM_MAX = {{(ACC_W - NUM_W){1'b0}}, {NUM_W{1'b1}}};

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    K_LIT  = 2'd0,
    K_SPEC = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    M_LIT      = 4'd0,
    M_FLAGS    = 4'd1,
    M_WNUM     = 4'd2,
    M_WSTAR    = 4'd3,
    M_WIDX     = 4'd4,
    M_AFTERW   = 4'd5,
    M_DOT      = 4'd6,
    M_PNUM     = 4'd7,
    M_PSTAR    = 4'd8,
    M_PIDX     = 4'd9,
    M_AFTERP   = 4'd10,
    M_LEN_L    = 4'd11,
    M_LEN_H    = 4'd12,
    M_LEN_DONE = 4'd13,
    M_BAD      = 4'd14,
    M_DRAIN    = 4'd15
  } mode_t;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_NEXT = 2'd1;
  localparam logic [1:0] SRC_IDX  = 2'd2;

  localparam logic [3:0] LM_NONE = 4'd0;
  localparam logic [3:0] LM_HH   = 4'd1;
  localparam logic [3:0] LM_H    = 4'd2;
  localparam logic [3:0] LM_L    = 4'd3;
  localparam logic [3:0] LM_LL   = 4'd4;
  localparam logic [3:0] LM_J    = 4'd5;
  localparam logic [3:0] LM_Z    = 4'd6;
  localparam logic [3:0] LM_T    = 4'd7;
  localparam logic [3:0] LM_BIGL = 4'd8;

  localparam int FL_LEFT  = 0;
  localparam int FL_PLUS  = 1;
  localparam int FL_SPACE = 2;
  localparam int FL_ALT   = 3;
  localparam int FL_ZERO  = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal_char;
    logic [4:0]  flags;
    logic [15:0] width;
    logic [1:0]  width_source;
    logic [15:0] width_arg_index;
    logic [15:0] precision;
    logic [1:0]  precision_source;
    logic [15:0] prec_arg_index;
    logic [3:0]  length_mod;
    logic [4:0]  conversion;
  } res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_conv;
    logic [4:0] conv;
  } cls_t;

  typedef struct packed {
    logic [4:0]       flags;
    logic [NUM_W-1:0] wval;
    logic [1:0]       wsrc;
    logic [NUM_W-1:0] widx;
    logic [NUM_W-1:0] pval;
    logic [1:0]       psrc;
    logic [NUM_W-1:0] pidx;
    logic [3:0]       len;
  } spec_t;

  // msb is the hit bit, low five bits the conversion code
  function automatic logic [5:0] conv_lookup(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      "d", "i": r = {1'b1, 5'd0};
      "o":      r = {1'b1, 5'd1};
      "u":      r = {1'b1, 5'd2};
      "x":      r = {1'b1, 5'd3};
      "X":      r = {1'b1, 5'd4};
      "f":      r = {1'b1, 5'd5};
      "F":      r = {1'b1, 5'd6};
      "e":      r = {1'b1, 5'd7};
      "E":      r = {1'b1, 5'd8};
      "g":      r = {1'b1, 5'd9};
      "G":      r = {1'b1, 5'd10};
      "a":      r = {1'b1, 5'd11};
      "A":      r = {1'b1, 5'd12};
      "c":      r = {1'b1, 5'd13};
      "s":      r = {1'b1, 5'd14};
      "p":      r = {1'b1, 5'd15};
      "n":      r = {1'b1, 5'd16};
      "%":      r = {1'b1, 5'd17};
      default:  r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/fst_front.sv]
// front end: accepts input words and classifies each character
module fst_front
  import fst_pkg::*;
(
  input  logic in_valid,
  input  in_t  in_word,
  output logic in_stall,
  input  logic q_full,
  output logic push,
  output cls_t push_word
);

  logic [5:0] conv_hit;

  assign conv_hit = conv_lookup(in_word.ch);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_word          = '0;
    push_word.ch       = in_word.ch;
    push_word.last     = in_word.last;
    push_word.is_digit = in_word.ch inside {["0":"9"]};
    push_word.digit    = 4'(in_word.ch - "0");
    push_word.is_conv  = conv_hit[5];
    push_word.conv     = conv_hit[4:0];
  end

endmodule

[sv/fst_queue.sv]
// small fifo of classified words between front and back
module fst_queue
  import fst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cls_t push_word,
  input  logic pop,
  output cls_t head,
  output logic q_valid,
  output logic q_full
);

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign head    = mem_r[rd_ptr_r];
  assign q_valid = cnt_r != '0;
  assign q_full  = cnt_r == Q_CW'(Q_DEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

[sv/fst_back.sv]
// back end: spec parser state machine and output register
module fst_back
  import fst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cls_t head,
  input  logic q_valid,
  output logic pop,
  output logic out_valid,
  output res_t out_word,
  input  logic out_stall
);

  mode_t            mode_r, mode_nxt;
  spec_t            spec_r, spec_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_word_r;
  res_t             res_nxt;
  logic             fire;
  logic             emit;
  logic [NUM_W-1:0] acc_sel;
  logic [ACC_W-1:0] acc_ext;
  logic [ACC_W-1:0] acc_sum;
  logic             acc_ovf;
  logic [NUM_W-1:0] acc_val;
  logic [NUM_W-1:0] dig;
  mode_t            ln_mode;
  logic [3:0]       ln_code;

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign pop       = fire;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign dig       = NUM_W'(head.digit);

  // decimal accumulate, shared by all four number fields
  always_comb begin
    case (mode_r)
      M_WNUM:  acc_sel = spec_r.wval;
      M_WIDX:  acc_sel = spec_r.widx;
      M_PNUM:  acc_sel = spec_r.pval;
      M_PIDX:  acc_sel = spec_r.pidx;
      default: acc_sel = '0;
    endcase
    acc_ext = {{(ACC_W - NUM_W){1'b0}}, acc_sel};
    acc_sum = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(head.digit);
    acc_ovf = acc_sum > NUM_MAX;
    acc_val = acc_sum[NUM_W-1:0];
  end

  // length modifier start
  always_comb begin
    ln_mode = M_LEN_DONE;
    ln_code = spec_r.len;
    case (head.ch)
      "l": begin
        ln_mode = M_LEN_L;
        ln_code = LM_L;
      end
      "h": begin
        ln_mode = M_LEN_H;
        ln_code = LM_H;
      end
      "j": ln_code = LM_J;
      "z": ln_code = LM_Z;
      "t": ln_code = LM_T;
      "L": ln_code = LM_BIGL;
      default: ln_mode = M_BAD;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    spec_nxt = spec_r;
    emit     = 1'b0;
    res_nxt  = '0;
    if (fire) begin
      if (mode_r == M_LIT) begin
        if (head.ch == "%") begin
          spec_nxt = '0;
          mode_nxt = M_FLAGS;
        end else begin
          emit                 = 1'b1;
          res_nxt.kind         = K_LIT;
          res_nxt.literal_char = head.ch;
        end
      end else if (mode_r != M_DRAIN) begin
        if (head.is_conv) begin
          emit = 1'b1;
          if (mode_r inside {M_WIDX, M_PIDX, M_BAD}) begin
            res_nxt.kind = K_ERR;
            mode_nxt     = M_DRAIN;
          end else begin
            res_nxt.kind             = K_SPEC;
            res_nxt.flags            = spec_r.flags;
            res_nxt.width            = 16'(spec_r.wval);
            res_nxt.width_source     = spec_r.wsrc;
            res_nxt.width_arg_index  = 16'(spec_r.widx);
            res_nxt.precision        = 16'(spec_r.pval);
            res_nxt.precision_source = spec_r.psrc;
            res_nxt.prec_arg_index   = 16'(spec_r.pidx);
            res_nxt.length_mod       = spec_r.len;
            res_nxt.conversion       = head.conv;
            mode_nxt                 = M_LIT;
            spec_nxt                 = '0;
          end
        end else if (mode_r != M_BAD) begin
          case (mode_r)
            M_FLAGS: begin
              case (head.ch)
                "-": spec_nxt.flags[FL_LEFT]  = 1'b1;
                "+": spec_nxt.flags[FL_PLUS]  = 1'b1;
                " ": spec_nxt.flags[FL_SPACE] = 1'b1;
                "#": spec_nxt.flags[FL_ALT]   = 1'b1;
                "0": spec_nxt.flags[FL_ZERO]  = 1'b1;
                "*": begin
                  spec_nxt.wsrc = SRC_NEXT;
                  mode_nxt      = M_WSTAR;
                end
                ".": mode_nxt = M_DOT;
                default: begin
                  if (head.is_digit) begin
                    spec_nxt.wval = dig;
                    mode_nxt      = M_WNUM;
                  end else begin
                    spec_nxt.len = ln_code;
                    mode_nxt     = ln_mode;
                  end
                end
              endcase
            end
            M_WNUM: begin
              if (head.is_digit) begin
                if (acc_ovf) begin
                  mode_nxt = M_BAD;
                end else begin
                  spec_nxt.wval = acc_val;
                end
              end else if (head.ch == ".") begin
                mode_nxt = M_DOT;
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_WSTAR: begin
              if (head.is_digit) begin
                spec_nxt.wsrc = SRC_IDX;
                spec_nxt.widx = dig;
                mode_nxt      = M_WIDX;
              end else if (head.ch == ".") begin
                mode_nxt = M_DOT;
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_WIDX: begin
              if (head.is_digit) begin
                if (acc_ovf) begin
                  mode_nxt = M_BAD;
                end else begin
                  spec_nxt.widx = acc_val;
                end
              end else if (head.ch == "$") begin
                mode_nxt = M_AFTERW;
              end else begin
                mode_nxt = M_BAD;
              end
            end
            M_AFTERW: begin
              if (head.ch == ".") begin
                mode_nxt = M_DOT;
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_DOT: begin
              if (head.is_digit) begin
                spec_nxt.pval = dig;
                mode_nxt      = M_PNUM;
              end else if (head.ch == "*") begin
                spec_nxt.psrc = SRC_NEXT;
                mode_nxt      = M_PSTAR;
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_PNUM: begin
              if (head.is_digit) begin
                if (acc_ovf) begin
                  mode_nxt = M_BAD;
                end else begin
                  spec_nxt.pval = acc_val;
                end
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_PSTAR: begin
              if (head.is_digit) begin
                spec_nxt.psrc = SRC_IDX;
                spec_nxt.pidx = dig;
                mode_nxt      = M_PIDX;
              end else begin
                spec_nxt.len = ln_code;
                mode_nxt     = ln_mode;
              end
            end
            M_PIDX: begin
              if (head.is_digit) begin
                if (acc_ovf) begin
                  mode_nxt = M_BAD;
                end else begin
                  spec_nxt.pidx = acc_val;
                end
              end else if (head.ch == "$") begin
                mode_nxt = M_AFTERP;
              end else begin
                mode_nxt = M_BAD;
              end
            end
            M_AFTERP: begin
              spec_nxt.len = ln_code;
              mode_nxt     = ln_mode;
            end
            M_LEN_L: begin
              if (head.ch == "l") begin
                spec_nxt.len = LM_LL;
                mode_nxt     = M_LEN_DONE;
              end else begin
                mode_nxt = M_BAD;
              end
            end
            M_LEN_H: begin
              if (head.ch == "h") begin
                spec_nxt.len = LM_HH;
                mode_nxt     = M_LEN_DONE;
              end else begin
                mode_nxt = M_BAD;
              end
            end
            default: mode_nxt = M_BAD;
          endcase
        end
      end
      if (head.last) begin
        mode_nxt = M_LIT;
        spec_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_LIT;
      spec_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      spec_r      <= spec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_word_r <= res_nxt;
    end
  end

  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && mode_r == M_DRAIN) |-> !emit)
    else $error("result emitted while draining after error");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && head.last) |=> (mode_r == M_LIT && spec_r == '0))
    else $error("parser state not cleared after last word");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit) |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

[sv/format_spec_tokenizer.sv]
// top level of the printf style format spec tokenizer
// Takes one format string character per word and gives a literal, a spec record or
// an error word. Sustained rate is one input word per cycle while out_stall does
// not hold the back end: the front classifies each character into a four entry
// queue, and the back parser consumes one queued word per cycle into a single
// output register. A result passes through a queue entry, then the output register.
// Words with no result are still popped. in_stall rises only when the queue is full.
module format_spec_tokenizer
  import fst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_word,
  output logic in_stall,
  output logic out_valid,
  output res_t out_word,
  input  logic out_stall
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  cls_t push_word;
  cls_t head;

  fst_front u_front (
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  fst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .q_valid   (q_valid),
    .q_full    (q_full)
  );

  fst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

[sim/tb_format_spec_tokenizer.sv]
// testbench for format_spec_tokenizer: directed and random format strings checked by a scoreboard
`timescale 1ns / 100ps

module tb_format_spec_tokenizer
  import fst_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CHARS = 360;

  class spec_scoreboard;
    mode_t       scan_mode;
    logic [4:0]  flag_acc;
    logic [15:0] wid_val;
    logic [1:0]  wid_src;
    logic [15:0] wid_idx;
    logic [15:0] prec_val;
    logic [1:0]  prec_src;
    logic [15:0] prec_idx;
    logic [3:0]  len_code;
    res_t        expected_results[$];
    int          mismatches;
    int          checked;

    function new();
      scan_mode = M_LIT;
      mismatches = 0;
      checked = 0;
      clear_spec();
    endfunction

    function void clear_spec();
      flag_acc = '0;
      wid_val = '0;
      wid_src = SRC_NONE;
      wid_idx = '0;
      prec_val = '0;
      prec_src = SRC_NONE;
      prec_idx = '0;
      len_code = LM_NONE;
    endfunction

    function int conv_of(byte unsigned c);
      case (c)
        "d", "i": return 0;
        "o": return 1;
        "u": return 2;
        "x": return 3;
        "X": return 4;
        "f": return 5;
        "F": return 6;
        "e": return 7;
        "E": return 8;
        "g": return 9;
        "G": return 10;
        "a": return 11;
        "A": return 12;
        "c": return 13;
        "s": return 14;
        "p": return 15;
        "n": return 16;
        "%": return 17;
        default: return -1;
      endcase
    endfunction

    function bit is_dig(byte unsigned c);
      return c >= "0" && c <= "9";
    endfunction

    // decimal accumulate, overflow past 16 bits makes the spec bad
    function mode_t push_digit(inout logic [15:0] v, input byte unsigned c, input mode_t stay);
      int unsigned n;
      n = v * 10 + (c - "0");
      if (n > 32'h0000_FFFF) return M_BAD;
      v = n[15:0];
      return stay;
    endfunction

    function mode_t take_length(byte unsigned c);
      case (c)
        "l": begin len_code = LM_L; return M_LEN_L; end
        "h": begin len_code = LM_H; return M_LEN_H; end
        "j": begin len_code = LM_J; return M_LEN_DONE; end
        "z": begin len_code = LM_Z; return M_LEN_DONE; end
        "t": begin len_code = LM_T; return M_LEN_DONE; end
        "L": begin len_code = LM_BIGL; return M_LEN_DONE; end
        default: return M_BAD;
      endcase
    endfunction

    function mode_t advance(mode_t m, byte unsigned c);
      case (m)
        M_FLAGS: begin
          case (c)
            "-": begin flag_acc[FL_LEFT] = 1'b1; return M_FLAGS; end
            "+": begin flag_acc[FL_PLUS] = 1'b1; return M_FLAGS; end
            " ": begin flag_acc[FL_SPACE] = 1'b1; return M_FLAGS; end
            "#": begin flag_acc[FL_ALT] = 1'b1; return M_FLAGS; end
            "0": begin flag_acc[FL_ZERO] = 1'b1; return M_FLAGS; end
            default: ;
          endcase
          if (is_dig(c)) begin
            wid_val = 16'(c - "0");
            return M_WNUM;
          end
          if (c == "*") begin wid_src = SRC_NEXT; return M_WSTAR; end
          if (c == ".") return M_DOT;
          return take_length(c);
        end
        M_WNUM: begin
          if (is_dig(c)) return push_digit(wid_val, c, M_WNUM);
          if (c == ".") return M_DOT;
          return take_length(c);
        end
        M_WSTAR: begin
          if (is_dig(c)) begin
            wid_src = SRC_IDX;
            wid_idx = 16'(c - "0");
            return M_WIDX;
          end
          if (c == ".") return M_DOT;
          return take_length(c);
        end
        M_WIDX: begin
          if (is_dig(c)) return push_digit(wid_idx, c, M_WIDX);
          return (c == "$") ? M_AFTERW : M_BAD;
        end
        M_AFTERW: begin
          if (c == ".") return M_DOT;
          return take_length(c);
        end
        M_DOT: begin
          if (is_dig(c)) begin
            prec_val = 16'(c - "0");
            return M_PNUM;
          end
          if (c == "*") begin prec_src = SRC_NEXT; return M_PSTAR; end
          return take_length(c);
        end
        M_PNUM: begin
          if (is_dig(c)) return push_digit(prec_val, c, M_PNUM);
          return take_length(c);
        end
        M_PSTAR: begin
          if (is_dig(c)) begin
            prec_src = SRC_IDX;
            prec_idx = 16'(c - "0");
            return M_PIDX;
          end
          return take_length(c);
        end
        M_PIDX: begin
          if (is_dig(c)) return push_digit(prec_idx, c, M_PIDX);
          return (c == "$") ? M_AFTERP : M_BAD;
        end
        M_AFTERP: return take_length(c);
        M_LEN_L: begin
          if (c == "l") begin len_code = LM_LL; return M_LEN_DONE; end
          return M_BAD;
        end
        M_LEN_H: begin
          if (c == "h") begin len_code = LM_HH; return M_LEN_DONE; end
          return M_BAD;
        end
        default: return M_BAD;
      endcase
    endfunction

    function void tokenize_char(in_t w, output bit has, output res_t r);
      byte unsigned c;
      int cv;
      c = w.ch;
      r = '0;
      has = 1'b0;
      if (scan_mode == M_LIT) begin
        if (c == "%") begin
          clear_spec();
          scan_mode = M_FLAGS;
        end else begin
          r.kind = K_LIT;
          r.literal_char = c;
          has = 1'b1;
        end
      end else if (scan_mode != M_DRAIN) begin
        cv = conv_of(c);
        if (cv >= 0) begin
          if (scan_mode == M_WIDX || scan_mode == M_PIDX || scan_mode == M_BAD) begin
            r.kind = K_ERR;
            scan_mode = M_DRAIN;
          end else begin
            r.kind = K_SPEC;
            r.flags = flag_acc;
            r.width = wid_val;
            r.width_source = wid_src;
            r.width_arg_index = wid_idx;
            r.precision = prec_val;
            r.precision_source = prec_src;
            r.prec_arg_index = prec_idx;
            r.length_mod = len_code;
            r.conversion = cv[4:0];
            scan_mode = M_LIT;
            clear_spec();
          end
          has = 1'b1;
        end else if (scan_mode != M_BAD) begin
          scan_mode = advance(scan_mode, c);
        end
      end
      if (w.last) begin
        scan_mode = M_LIT;
        clear_spec();
      end
    endfunction

    function void note_word(in_t w);
      bit   has;
      res_t r;
      tokenize_char(w, has, r);
      if (has) expected_results.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task cmp(string field, logic [15:0] e, logic [15:0] g);
      if (g !== e)
        report($sformatf("result %0d %s expected %0h got %0h", checked, field, e, g));
    endtask

    task check_word(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d", got.kind));
        return;
      end
      e = expected_results.pop_front();
      cmp("kind", 16'(e.kind), 16'(got.kind));
      cmp("literal_char", 16'(e.literal_char), 16'(got.literal_char));
      cmp("flags", 16'(e.flags), 16'(got.flags));
      cmp("width", e.width, got.width);
      cmp("width_source", 16'(e.width_source), 16'(got.width_source));
      cmp("width_arg_index", e.width_arg_index, got.width_arg_index);
      cmp("precision", e.precision, got.precision);
      cmp("precision_source", 16'(e.precision_source), 16'(got.precision_source));
      cmp("prec_arg_index", e.prec_arg_index, got.prec_arg_index);
      cmp("length_mod", 16'(e.length_mod), 16'(got.length_mod));
      cmp("conversion", 16'(e.conversion), 16'(got.conversion));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  in_t  in_word;
  logic in_stall;
  logic out_valid;
  res_t out_word;
  logic out_stall = 1'b0;

  spec_scoreboard sb;
  bit             idle_on;
  int             cycle_count;
  int             stall_left;
  byte unsigned   char_buf[$];
  string          flag_chars = "#0- +";
  string          conv_chars = "diouxXfFeEgGaAcspn%";
  string          len_opts[9] = '{"", "h", "hh", "l", "ll", "j", "z", "t", "L"};

  format_spec_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("format_spec_tokenizer test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  task automatic send_char(input byte unsigned c, input bit last);
    in_t w;
    int  gap;
    w.ch = c;
    w.last = last;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic flush_chars(input bit last_at_end);
    for (int i = 0; i < char_buf.size(); i++)
      send_char(char_buf[i], last_at_end && i == char_buf.size() - 1);
    char_buf.delete();
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
  endfunction

  function automatic int unsigned pick_number();
    case ($urandom_range(0, 7))
      4: return $urandom_range(100, 9999);
      5: return $urandom_range(10000, 65535);
      6: return 65535;
      7: return $urandom_range(65536, 999999);
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  // one spec: flags, width, precision, length, conversion; broken ones get a byte added or lost
  function automatic void add_spec(bit broken);
    int          start;
    int          pos;
    int unsigned n;
    start = char_buf.size();
    char_buf.push_back("%");
    repeat ($urandom_range(0, 3)) char_buf.push_back(flag_chars[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      1: begin
        n = pick_number();
        add_text($sformatf("%0d", (n == 0) ? 1 : n));
      end
      2: add_text("*");
      3: add_text($sformatf("*%0d$", pick_number()));
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      add_text(".");
      case ($urandom_range(0, 3))
        1: add_text($sformatf("%s%0d", $urandom_range(0, 3) == 0 ? "0" : "", pick_number()));
        2: add_text("*");
        3: add_text($sformatf("*%0d$", pick_number()));
        default: ;
      endcase
    end
    add_text(len_opts[$urandom_range(0, 8)]);
    char_buf.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
    if (broken) begin
      pos = $urandom_range(start + 1, char_buf.size() - 1);
      if ($urandom_range(0, 1)) char_buf.insert(pos, 8'($urandom_range(0, 255)));
      else char_buf.delete(pos);
    end
  endfunction

  function automatic void add_noise(int lo, int hi, bit no_percent);
    byte unsigned b;
    repeat ($urandom_range(lo, hi)) begin
      b = $urandom_range(0, 255);
      if (no_percent && b == "%") b = "q";
      char_buf.push_back(b);
    end
  endfunction

  initial begin
    int  sent;
    int  sel;
    bit  paused;
    bit  last_end;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    idle_on = 1'b1;
    cycle_count = 0;
    sent = 0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // literal extremes and the percent conversion
    char_buf.push_back(8'h00);
    char_buf.push_back(8'hFF);
    add_text("%%%-+ #0*3$.*65535$llx%65535.007hhu");
    flush_chars(1'b0);
    add_text("%.s%*.*Lf%*0$.5jd%zo%tp%hn%lc%12");
    flush_chars(1'b1);
    // mixed width, missing dollar, oversize number, bad length: errors then ignored input
    add_text("%5*dab%d");
    flush_chars(1'b1);
    add_text("%*12dx");
    flush_chars(1'b1);
    add_text("%65536i%d");
    flush_chars(1'b1);
    add_text("%lqd");
    flush_chars(1'b1);
    pause_until_drained();

    while (sent < RANDOM_CHARS) begin
      idle_on = (sent < RANDOM_CHARS - 90) && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        add_noise(0, 3, 1'b1);
        add_spec(1'b0);
        add_noise(0, 2, 1'b1);
      end else if (sel < 8) begin
        add_noise(1, 6, 1'b0);
      end else begin
        add_spec(1'b1);
      end
      last_end = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0 && char_buf.size() > 1) begin
        void'(char_buf.pop_back());
        last_end = 1'b1;
      end
      sent += char_buf.size();
      flush_chars(last_end);
      if (!paused && sent > RANDOM_CHARS / 2) begin
        paused = 1'b1;
        pause_until_drained();
      end
    end

    idle_on = 1'b0;
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("format_spec_tokenizer test passed");
    end else begin
      $display("format_spec_tokenizer test failed");
    end
    $finish;
  end

endmodule
